### design/eqds_pkg.sv
// ----------------------------------------------------------------------------
// Event queue package
// Shared constants and types for the event queue with delayed slots.
// ----------------------------------------------------------------------------
package eqds_pkg;
	localparam int QUEUE_DEPTH = 16;
	localparam int DELAY_SLOTS = 8;
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int SW = (DELAY_SLOTS > 1) ? $clog2(DELAY_SLOTS) : 1;
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [31:0] DELAY_LIMIT = 32'h8000_0000;

	typedef enum logic [2:0] {
		K_POST = 3'd0, K_POST_REPL = 3'd1, K_DELAYED = 3'd2, K_DELAYED_REPL = 3'd3,
		K_CANCEL = 3'd4, K_POP = 3'd5, K_TICK_ADD = 3'd6, K_TICK_SET = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_FULL = 3'd1, ST_BAD_DELAY = 3'd2, ST_NOT_FOUND = 3'd3,
		ST_EMPTY = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_QSCAN, S_QCHK, S_SSCAN, S_SCHK, S_DUESCAN, S_DUECHK,
		S_HEADRD, S_HEADWAIT, S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] event_id;
		logic [31:0] event_tag;
		logic [31:0] time_amount;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] popped_id;
		logic [31:0] popped_tag;
		logic        popped_unregistered;
		logic [4:0]  queued_now;
		logic [31:0] drops_total;
		logic [31:0] tick_now;
	} rsp_t;
endpackage

### design/eqds_if.sv
// ----------------------------------------------------------------------------
// Request and response channel interfaces
// Valid and ready handshakes, each carrying one payload.
// ----------------------------------------------------------------------------
interface eqds_req_if import eqds_pkg::*; ();
	logic valid;
	logic ready;
	req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface eqds_rsp_if import eqds_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### design/event_queue_with_delayed_slots.sv
// ----------------------------------------------------------------------------
// Event queue with delayed slots
// Circular event queue with timed slots, tick counter and drop counter.
// ----------------------------------------------------------------------------
// The block takes one request at a time on req and answers each with one
// response on rsp. Requests post, replace, delay, cancel or pop events, or
// advance or set the tick counter. The queue and the slot pool each live in
// a synchronous memory with a registered read port; busy bits of the
// slots are flip-flops.
// Post and tick requests need no scan. Post replace scans the queue from
// the newest entry, one memory read per entry. Delayed requests, including
// those with a bad delay, and cancel scan every slot of the slot memory.
// Pop scans all slots for due entries and then reads the head. The scans
// set the rate.
// After reset the queue is empty, no slot is busy and both counters are
// zero; no clearing pass is needed. A response waits in its output register
// while the receiver stalls, and no new request is taken until it leaves.
// registered_events is written through cfg_we and cfg_data.
module event_queue_with_delayed_slots import eqds_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	eqds_req_if.sink    req,
	eqds_rsp_if.source  rsp
);
	logic [15:0] qid_mem [QUEUE_DEPTH];
	logic [31:0] qtag_mem [QUEUE_DEPTH];
	logic [31:0] sdue_mem [DELAY_SLOTS];
	logic [15:0] sid_mem [DELAY_SLOTS];
	logic [31:0] stag_mem [DELAY_SLOTS];

	state_t state_q, state_d;
	req_t r_q;
	logic [15:0] reg_ev_q;
	logic [QW-1:0] head_q;
	logic [FW-1:0] fill_q;
	logic [DELAY_SLOTS-1:0] busy_q;
	logic [31:0] tick_q, drops_q;
	logic [FW-1:0] qcnt_q;
	logic [SW:0] scnt_q;
	logic [SW-1:0] hit_q;
	logic hit_v_q;
	logic rsp_v_q;
	rsp_t rsp_q;

	logic [QW-1:0] q_rd_addr;
	logic [15:0] q_rd_id;
	logic [31:0] q_rd_tag;
	logic [SW-1:0] s_rd_addr;
	logic [31:0] s_rd_due;
	logic [15:0] s_rd_id;
	logic [31:0] s_rd_tag;

	logic [QW-1:0] tail_pos;
	logic [QW-1:0] scan_pos;
	logic [SW-1:0] sidx;
	logic [SW-1:0] free_idx;
	logic free_any;
	logic [31:0] due_diff;
	status_t idle_status;

	assign req.ready = (state_q == S_IDLE) && !rsp_v_q;
	assign rsp.valid = rsp_v_q;
	assign rsp.payload = rsp_q;

	assign tail_pos = QW'(head_q + QW'(fill_q));
	assign scan_pos = QW'(head_q + QW'(qcnt_q) - QW'(1));
	assign sidx = scnt_q[SW-1:0];
	assign due_diff = tick_q - s_rd_due;
	assign idle_status = (kind_t'(req.payload.kind) == K_POST &&
		fill_q == FW'(QUEUE_DEPTH)) ? ST_FULL : ST_OK;

	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = DELAY_SLOTS - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_any = 1'b1;
				free_idx = SW'(i);
			end
		end
	end

	always_comb begin
		q_rd_addr = (state_q == S_HEADRD) ? head_q : scan_pos;
		s_rd_addr = sidx;
	end

	always_ff @(posedge clk) begin
		q_rd_id <= qid_mem[q_rd_addr];
		q_rd_tag <= qtag_mem[q_rd_addr];
		s_rd_due <= sdue_mem[s_rd_addr];
		s_rd_id <= sid_mem[s_rd_addr];
		s_rd_tag <= stag_mem[s_rd_addr];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid && req.ready) begin
					unique case (kind_t'(req.payload.kind))
						K_POST_REPL: state_d = S_QSCAN;
						K_DELAYED, K_DELAYED_REPL, K_CANCEL: state_d = S_SSCAN;
						K_POP: state_d = S_DUESCAN;
						default: state_d = S_DONE;
					endcase
				end
			end
			S_QSCAN: state_d = (qcnt_q == '0) ? S_DONE : S_QCHK;
			S_QCHK: state_d = (q_rd_id == r_q.event_id) ? S_DONE : S_QSCAN;
			S_SSCAN: state_d = (scnt_q == (SW+1)'(DELAY_SLOTS)) ? S_DONE : S_SCHK;
			S_SCHK: state_d = S_SSCAN;
			S_DUESCAN: state_d = (scnt_q == (SW+1)'(DELAY_SLOTS)) ? S_HEADRD : S_DUECHK;
			S_DUECHK: state_d = S_DUESCAN;
			S_HEADRD: state_d = S_HEADWAIT;
			S_HEADWAIT: state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Memory writes.
	always_ff @(posedge clk) begin
		if (state_q == S_QCHK && q_rd_id == r_q.event_id) begin
			qtag_mem[scan_pos] <= r_q.event_tag;
		end else if (state_q == S_QSCAN && qcnt_q == '0 && fill_q != FW'(QUEUE_DEPTH)) begin
			qid_mem[tail_pos] <= r_q.event_id;
			qtag_mem[tail_pos] <= r_q.event_tag;
		end else if (state_q == S_IDLE && req.valid && req.ready &&
			kind_t'(req.payload.kind) == K_POST && fill_q != FW'(QUEUE_DEPTH)) begin
			qid_mem[tail_pos] <= req.payload.event_id;
			qtag_mem[tail_pos] <= req.payload.event_tag;
		end else if (state_q == S_DUECHK && busy_q[sidx] && !due_diff[31] &&
			fill_q != FW'(QUEUE_DEPTH)) begin
			qid_mem[tail_pos] <= s_rd_id;
			qtag_mem[tail_pos] <= s_rd_tag;
		end
		if (state_q == S_SSCAN && scnt_q == (SW+1)'(DELAY_SLOTS) &&
			kind_t'(r_q.kind) != K_CANCEL && (hit_v_q || free_any) &&
			!(r_q.time_amount == '0 || r_q.time_amount >= DELAY_LIMIT)) begin
			sdue_mem[hit_v_q ? hit_q : free_idx] <= tick_q + r_q.time_amount;
			stag_mem[hit_v_q ? hit_q : free_idx] <= r_q.event_tag;
			sid_mem[hit_v_q ? hit_q : free_idx] <= r_q.event_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			r_q <= '0;
			reg_ev_q <= '0;
			head_q <= '0;
			fill_q <= '0;
			busy_q <= '0;
			tick_q <= '0;
			drops_q <= '0;
			qcnt_q <= '0;
			scnt_q <= '0;
			hit_q <= '0;
			hit_v_q <= 1'b0;
			rsp_v_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				reg_ev_q <= cfg_data;
			end
			if (rsp_v_q && rsp.ready) begin
				rsp_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						r_q <= req.payload;
						qcnt_q <= fill_q;
						scnt_q <= '0;
						hit_v_q <= 1'b0;
						rsp_q <= rsp_t'({idle_status, {($bits(rsp_t) - 3){1'b0}}});
						unique case (kind_t'(req.payload.kind))
							K_POST: begin
								if (fill_q == FW'(QUEUE_DEPTH)) begin
									drops_q <= drops_q + 32'd1;
								end else begin
									fill_q <= fill_q + FW'(1);
								end
							end
							K_TICK_ADD: tick_q <= tick_q + req.payload.time_amount;
							K_TICK_SET: tick_q <= req.payload.time_amount;
							default: ;
						endcase
					end
				end
				S_QSCAN: begin
					if (qcnt_q == '0) begin
						if (fill_q == FW'(QUEUE_DEPTH)) begin
							drops_q <= drops_q + 32'd1;
							rsp_q.status <= ST_FULL;
						end else begin
							fill_q <= fill_q + FW'(1);
						end
					end
				end
				S_QCHK: qcnt_q <= qcnt_q - FW'(1);
				S_SSCAN: begin
					if (scnt_q == (SW+1)'(DELAY_SLOTS)) begin
						if (kind_t'(r_q.kind) == K_CANCEL) begin
							if (hit_v_q) begin
								busy_q[hit_q] <= 1'b0;
							end else begin
								rsp_q.status <= ST_NOT_FOUND;
							end
						end else if (r_q.time_amount == '0 || r_q.time_amount >= DELAY_LIMIT) begin
							rsp_q.status <= ST_BAD_DELAY;
						end else if (!hit_v_q) begin
							if (free_any) begin
								busy_q[free_idx] <= 1'b1;
							end else begin
								drops_q <= drops_q + 32'd1;
								rsp_q.status <= ST_FULL;
							end
						end
					end
				end
				S_SCHK: begin
					if (!hit_v_q && busy_q[sidx] && s_rd_id == r_q.event_id &&
						((kind_t'(r_q.kind) == K_DELAYED_REPL) ||
						(kind_t'(r_q.kind) == K_CANCEL && s_rd_tag == r_q.event_tag))) begin
						hit_v_q <= 1'b1;
						hit_q <= sidx;
					end
					scnt_q <= scnt_q + (SW+1)'(1);
				end
				S_DUECHK: begin
					if (busy_q[sidx] && !due_diff[31]) begin
						busy_q[sidx] <= 1'b0;
						if (fill_q == FW'(QUEUE_DEPTH)) begin
							drops_q <= drops_q + 32'd1;
						end else begin
							fill_q <= fill_q + FW'(1);
						end
					end
					scnt_q <= scnt_q + (SW+1)'(1);
				end
				S_HEADWAIT: begin
					if (fill_q == '0) begin
						rsp_q.status <= ST_EMPTY;
					end else begin
						rsp_q.popped_id <= q_rd_id;
						rsp_q.popped_tag <= q_rd_tag;
						head_q <= head_q + QW'(1);
						fill_q <= fill_q - FW'(1);
						if (q_rd_id >= reg_ev_q) begin
							rsp_q.popped_unregistered <= 1'b1;
							drops_q <= drops_q + 32'd1;
						end
					end
				end
				S_DONE: begin
					rsp_q.queued_now <= 5'(fill_q);
					rsp_q.drops_total <= drops_q;
					rsp_q.tick_now <= tick_q;
					rsp_v_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end
endmodule

### design/eqds_checker.sv
// ----------------------------------------------------------------------------
// Event queue port checker
// Port-level assertions on the request and response channels.
// ----------------------------------------------------------------------------
module eqds_checker import eqds_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_payload
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("response changed while stalled");
	a_no_req_with_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request taken while a response waits");
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_payload.queued_now <= 5'(QUEUE_DEPTH))
		else $error("queue fill out of range");
	a_pop_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.status != ST_OK |->
		rsp_payload.popped_id == '0 && !rsp_payload.popped_unregistered)
		else $error("popped fields set on a failed request");
endmodule

bind event_queue_with_delayed_slots eqds_checker u_eqds_checker (
	.clk(clk), .arst_n(arst_n), .req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload)
);

### tb/sv/tb_event_queue_with_delayed_slots.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event queue with delayed slots testbench
// Drives queue, slot, cancel, pop and tick requests with random idling and
// stalls. A behavioral copy of the queue, the slot pool and the counters
// predicts every response, and each response is compared field by field.
// ----------------------------------------------------------------------------
module tb_event_queue_with_delayed_slots;
	import eqds_pkg::*;

	localparam int IDLE_LIMIT = 4000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_data;

	eqds_req_if req ();
	eqds_rsp_if rsp ();

	event_queue_with_delayed_slots DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.req(req.sink), .rsp(rsp.source)
	);

	req_t pending_reqs[$];
	rsp_t expected_rsps[$];
	int error_count = 0;
	int accepted_count = 0;
	int checked_count = 0;
	int pop_count = 0;
	int drop_seen = 0;
	bit quiet_phase = 0;
	int hold_rsp = 0;
	bit sender_pause = 0;
	bit timed_out = 0;
	int idle_cycles = 0;
	bit req_taken = 0;

	// Predictor state.
	logic [15:0] reg_events;
	logic [15:0] q_ids [QUEUE_DEPTH];
	logic [31:0] q_tags [QUEUE_DEPTH];
	int q_head;
	int q_fill;
	bit sl_busy [DELAY_SLOTS];
	logic [31:0] sl_due [DELAY_SLOTS];
	logic [15:0] sl_id [DELAY_SLOTS];
	logic [31:0] sl_tag [DELAY_SLOTS];
	logic [31:0] ticks;
	logic [31:0] drops;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic status_t enqueue_event(logic [15:0] id, logic [31:0] tag);
		int p;
		if (q_fill >= QUEUE_DEPTH) begin
			drops++;
			return ST_FULL;
		end
		p = (q_head + q_fill) % QUEUE_DEPTH;
		q_ids[p] = id;
		q_tags[p] = tag;
		q_fill++;
		return ST_OK;
	endfunction

	function automatic status_t arm_slot(req_t r, bit replace);
		int s;
		s = -1;
		if (r.time_amount == 0 || r.time_amount >= DELAY_LIMIT)
			return ST_BAD_DELAY;
		if (replace) begin
			for (int k = 0; k < DELAY_SLOTS; k++)
				if (s < 0 && sl_busy[k] && sl_id[k] == r.event_id)
					s = k;
		end
		if (s < 0) begin
			for (int k = 0; k < DELAY_SLOTS; k++)
				if (s < 0 && !sl_busy[k])
					s = k;
			if (s < 0) begin
				drops++;
				return ST_FULL;
			end
			sl_busy[s] = 1;
			sl_id[s] = r.event_id;
		end
		sl_due[s] = ticks + r.time_amount;
		sl_tag[s] = r.event_tag;
		return ST_OK;
	endfunction

	function automatic rsp_t predict_event_step(req_t r);
		rsp_t o;
		status_t st;
		int s;
		bit hit;
		logic [31:0] diff;
		o = '0;
		st = ST_OK;
		case (kind_t'(r.kind))
			K_POST: st = enqueue_event(r.event_id, r.event_tag);
			K_POST_REPL: begin
				hit = 0;
				for (int k = q_fill; k > 0 && !hit; k--) begin
					s = (q_head + k - 1) % QUEUE_DEPTH;
					if (q_ids[s] == r.event_id) begin
						q_tags[s] = r.event_tag;
						hit = 1;
					end
				end
				if (!hit)
					st = enqueue_event(r.event_id, r.event_tag);
			end
			K_DELAYED: st = arm_slot(r, 0);
			K_DELAYED_REPL: st = arm_slot(r, 1);
			K_CANCEL: begin
				s = -1;
				for (int k = 0; k < DELAY_SLOTS; k++)
					if (s < 0 && sl_busy[k] && sl_id[k] == r.event_id
							&& sl_tag[k] == r.event_tag)
						s = k;
				if (s >= 0)
					sl_busy[s] = 0;
				else
					st = ST_NOT_FOUND;
			end
			K_POP: begin
				for (int k = 0; k < DELAY_SLOTS; k++) begin
					diff = ticks - sl_due[k];
					if (sl_busy[k] && !diff[31]) begin
						sl_busy[k] = 0;
						void'(enqueue_event(sl_id[k], sl_tag[k]));
					end
				end
				if (q_fill == 0) begin
					st = ST_EMPTY;
				end else begin
					o.popped_id = q_ids[q_head];
					o.popped_tag = q_tags[q_head];
					q_head = (q_head + 1) % QUEUE_DEPTH;
					q_fill--;
					if (o.popped_id >= reg_events) begin
						o.popped_unregistered = 1;
						drops++;
					end
				end
			end
			K_TICK_ADD: ticks = ticks + r.time_amount;
			default: ticks = r.time_amount;
		endcase
		o.status = st;
		o.queued_now = q_fill[4:0];
		o.drops_total = drops;
		o.tick_now = ticks;
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on response %0d: %s got %h expected %h",
			checked_count, what, got, want);
		error_count++;
	endtask

	// Request driver. A request stays on the bus until the monitor has seen it taken.
	always @(negedge clk) begin
		int gap;
		if (!arst_n) begin
			req.valid <= 0;
		end else if (!req.valid || req_taken) begin
			req_taken = 0;
			if (pending_reqs.size() > 0 && !sender_pause) begin
				if (!quiet_phase && $urandom_range(0, 9) == 0) begin
					req.valid <= 0;
					gap = $urandom_range(1, 15);
					repeat (gap) @(negedge clk);
				end
				req.payload <= pending_reqs.pop_front();
				req.valid <= 1;
			end else begin
				req.valid <= 0;
			end
		end
	end

	// Response ready with random stall bursts and a long hold-off on request.
	always @(negedge clk) begin
		int stall;
		if (!arst_n) begin
			rsp.ready <= 0;
		end else if (hold_rsp > 0) begin
			rsp.ready <= 0;
			hold_rsp--;
		end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
			rsp.ready <= 0;
			stall = $urandom_range(1, 15);
			repeat (stall - 1) @(negedge clk);
		end else begin
			rsp.ready <= 1;
		end
	end

	// Monitor: predicts on accepted requests and checks accepted responses.
	always @(posedge clk) begin
		rsp_t want;
		rsp_t got;
		if (arst_n) begin
			if (req.valid && req.ready) begin
				expected_rsps.push_back(predict_event_step(req.payload));
				accepted_count++;
				req_taken = 1;
				if (req.payload.kind == K_POP)
					pop_count++;
			end
			if (rsp.valid && rsp.ready) begin
				got = rsp.payload;
				if (expected_rsps.size() == 0) begin
					$display("unexpected response %h", got);
					error_count++;
				end else begin
					want = expected_rsps.pop_front();
					if (got.status != want.status)
						report_mismatch("status", got.status, want.status);
					if (got.popped_id != want.popped_id)
						report_mismatch("popped_id", got.popped_id, want.popped_id);
					if (got.popped_tag != want.popped_tag)
						report_mismatch("popped_tag", got.popped_tag, want.popped_tag);
					if (got.popped_unregistered != want.popped_unregistered)
						report_mismatch("popped_unregistered", got.popped_unregistered,
							want.popped_unregistered);
					if (got.queued_now != want.queued_now)
						report_mismatch("queued_now", got.queued_now, want.queued_now);
					if (got.drops_total != want.drops_total)
						report_mismatch("drops_total", got.drops_total, want.drops_total);
					if (got.tick_now != want.tick_now)
						report_mismatch("tick_now", got.tick_now, want.tick_now);
					if (want.drops_total != 0)
						drop_seen = 1;
				end
				checked_count++;
			end
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("timeout after %0d cycles without a handshake", idle_cycles);
			$display("status: fail");
			$finish;
		end
	end

	function automatic req_t make_req(kind_t k, logic [15:0] id, logic [31:0] tag,
			logic [31:0] amt);
		req_t r;
		r.kind = k;
		r.event_id = id;
		r.event_tag = tag;
		r.time_amount = amt;
		return r;
	endfunction

	function automatic req_t random_req();
		int pick;
		logic [31:0] amt;
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 5))
			0: amt = $urandom;
			1: amt = 0;
			2: amt = 32'h8000_0000 | $urandom;
			default: amt = $urandom_range(1, 40);
		endcase
		if (pick < 18)
			return make_req(K_POST, $urandom_range(0, 12), $urandom, amt);
		if (pick < 30)
			return make_req(K_POST_REPL, $urandom_range(0, 12), $urandom, amt);
		if (pick < 42)
			return make_req(K_DELAYED, $urandom_range(0, 12), $urandom, amt);
		if (pick < 50)
			return make_req(K_DELAYED_REPL, $urandom_range(0, 12), $urandom, amt);
		if (pick < 56)
			return make_req(K_CANCEL, $urandom_range(0, 12), $urandom_range(0, 3), amt);
		if (pick < 82)
			return make_req(K_POP, $urandom, $urandom, $urandom);
		if (pick < 94)
			return make_req(K_TICK_ADD, $urandom, $urandom, $urandom_range(0, 30));
		if (pick < 97)
			return make_req(K_TICK_SET, $urandom, $urandom, $urandom);
		return make_req(kind_t'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() > 0 || req.valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_registered(logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 0;
		reg_events = value;
	endtask

	initial begin
		logic [15:0] cfg_values [4];
		cfg_values = '{16'd0, 16'd6, 16'hFFFF, 16'd9};
		arst_n = 0;
		cfg_we = 0;
		cfg_data = '0;
		req.valid = 0;
		req.payload = '0;
		rsp.ready = 0;
		reg_events = 0;
		q_head = 0;
		q_fill = 0;
		ticks = 0;
		drops = 0;
		foreach (sl_busy[k]) sl_busy[k] = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		write_registered(16'd5);
		// Directed: empty pop, field extremes, full queue, replace, slots, cancel.
		pending_reqs.push_back(make_req(K_POP, 16'h0, 32'h0, 32'h0));
		pending_reqs.push_back(make_req(K_POST, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		pending_reqs.push_back(make_req(K_POST, 16'h0003, 32'h0000_0001, 32'h0));
		pending_reqs.push_back(make_req(K_POST_REPL, 16'h0003, 32'hA5A5_5A5A, 32'h0));
		pending_reqs.push_back(make_req(K_POST_REPL, 16'h0004, 32'h1234_5678, 32'h0));
		pending_reqs.push_back(make_req(K_DELAYED, 16'h0002, 32'h11, 32'h0));
		pending_reqs.push_back(make_req(K_DELAYED, 16'h0002, 32'h11, 32'h8000_0000));
		pending_reqs.push_back(make_req(K_DELAYED, 16'h0002, 32'h11, 32'h7FFF_FFFF));
		pending_reqs.push_back(make_req(K_DELAYED, 16'h0001, 32'h22, 32'h1));
		pending_reqs.push_back(make_req(K_DELAYED_REPL, 16'h0001, 32'h33, 32'h2));
		pending_reqs.push_back(make_req(K_CANCEL, 16'h0001, 32'h22, 32'h0));
		pending_reqs.push_back(make_req(K_CANCEL, 16'h0002, 32'h11, 32'h0));
		pending_reqs.push_back(make_req(K_TICK_ADD, 16'h0, 32'h0, 32'hFFFF_FFFF));
		pending_reqs.push_back(make_req(K_TICK_SET, 16'h0, 32'h0, 32'hFFFF_FFFE));
		pending_reqs.push_back(make_req(K_TICK_ADD, 16'h0, 32'h0, 32'h5));
		for (int k = 0; k < 9; k++)
			pending_reqs.push_back(make_req(K_DELAYED, k[15:0], k, 32'h1));
		pending_reqs.push_back(make_req(K_TICK_ADD, 16'h0, 32'h0, 32'h3));
		for (int k = 0; k < 14; k++)
			pending_reqs.push_back(make_req(K_POST, k[15:0] + 16'd8, k, 32'h0));
		for (int k = 0; k < 20; k++)
			pending_reqs.push_back(make_req(K_POP, 16'h0, 32'h0, 32'h0));
		wait_drained();

		// Long receiver hold-off while the sender keeps offering requests.
		for (int k = 0; k < 20; k++)
			pending_reqs.push_back(random_req());
		hold_rsp = 300;
		wait_drained();

		for (int phase = 0; phase < 4; phase++) begin
			write_registered(cfg_values[phase]);
			if (phase == 3)
				quiet_phase = 1;
			for (int k = 0; k < 118; k++)
				pending_reqs.push_back(random_req());
			if (phase == 1) begin
				// Sender pauses until every response has come back.
				while (pending_reqs.size() > 60) @(posedge clk);
				sender_pause = 1;
				while (req.valid || expected_rsps.size() > 0) @(posedge clk);
				repeat (20) @(posedge clk);
				sender_pause = 0;
			end
			wait_drained();
		end

		$display("covered %0d requests, %0d pops, %0d responses checked",
			accepted_count, pop_count, checked_count);
		$display("four registered_events settings, drops observed: %0d", drop_seen);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

### files.f
design/eqds_pkg.sv
design/eqds_if.sv
design/event_queue_with_delayed_slots.sv
design/eqds_checker.sv
tb/sv/tb_event_queue_with_delayed_slots.sv
